// File: sv/blist_pkg.sv
// Package for the bounded ordered list: sizes, command and status codes,
// and the control word that the top level broadcasts to the cell row.
// No dependencies.
package blist_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int POS_W  = 6;
    localparam int STAT_W = 2;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND     = 3'd0,
        CMD_INS_FRONT  = 3'd1,
        CMD_INS_POS    = 3'd2,
        CMD_DEL_FRONT  = 3'd3,
        CMD_DEL_BACK   = 3'd4,
        CMD_DEL_POS    = 3'd5,
        CMD_DISPLAY    = 3'd6
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_BADPOS = 2'd3
    } stat_t;

    typedef enum logic [1:0] {
        SH_HOLD   = 2'd0,
        SH_INSERT = 2'd1,
        SH_DELETE = 2'd2,
        SH_ROTATE = 2'd3
    } shift_op_t;

    typedef struct packed {
        shift_op_t                op;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

// File: sv/blist_cell.sv
// One storage cell of the list row. Holds one entry and moves data to or
// from its neighbors under the broadcast control word. Uses blist_pkg.
module blist_cell (
    input  logic                              clk,
    input  logic [blist_pkg::IDX_W-1:0]       cell_idx,
    input  blist_pkg::cell_ctrl_t             ctrl,
    input  logic signed [blist_pkg::DATA_W-1:0] left_val,
    input  logic signed [blist_pkg::DATA_W-1:0] right_val,
    input  logic signed [blist_pkg::DATA_W-1:0] front_val,
    output logic signed [blist_pkg::DATA_W-1:0] value_out
);

    logic signed [blist_pkg::DATA_W-1:0] value_reg;
    logic signed [blist_pkg::DATA_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        case (ctrl.op)
            blist_pkg::SH_INSERT:
            begin
                if (cell_idx > ctrl.idx)
                begin
                    value_next = left_val;
                end
                else if (cell_idx == ctrl.idx)
                begin
                    value_next = ctrl.value;
                end
            end
            blist_pkg::SH_DELETE:
            begin
                if (cell_idx >= ctrl.idx)
                begin
                    value_next = right_val;
                end
            end
            blist_pkg::SH_ROTATE:
            begin
                if (cell_idx < ctrl.idx)
                begin
                    value_next = right_val;
                end
                else if (cell_idx == ctrl.idx)
                begin
                    value_next = front_val;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value_out = value_reg;

endmodule

// File: sv/bounded_ordered_list.sv
// An edit command shows its result in the output register in the cycle after acceptance.
// Throughput: one edit per cycle while the output is not stalled and no display runs. A display
// of N entries holds the input until all N are emitted, one result per cycle while not stalled;
// each is read from cell 0, then registered, with one rotation step of the cell row per entry.
// Reset clears the entry count, the sequencer and the output valid; cell contents stay undefined.
// Uses blist_pkg and blist_cell.
module bounded_ordered_list (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [blist_pkg::CMD_W-1:0]         command,
    input  logic signed [blist_pkg::DATA_W-1:0] data_value,
    input  logic [blist_pkg::POS_W-1:0]         position,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [blist_pkg::DATA_W-1:0] entry_value,
    output logic                                last,
    output logic [blist_pkg::STAT_W-1:0]        status,
    output logic [blist_pkg::CNT_W-1:0]         entry_count
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DISP = 2'b10
    } state_t;

    state_t                              state_reg;
    state_t                              state_next;
    logic [blist_pkg::CNT_W-1:0]         count_reg;
    logic [blist_pkg::CNT_W-1:0]         count_next;
    logic [blist_pkg::CNT_W-1:0]         rem_reg;
    logic [blist_pkg::CNT_W-1:0]         rem_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic signed [blist_pkg::DATA_W-1:0] entry_reg;
    logic signed [blist_pkg::DATA_W-1:0] entry_next;
    logic                                last_reg;
    logic                                last_next;
    blist_pkg::stat_t                    status_reg;
    blist_pkg::stat_t                    status_next;
    logic [blist_pkg::CNT_W-1:0]         ecount_reg;
    logic [blist_pkg::CNT_W-1:0]         ecount_next;

    logic                                out_free;
    logic                                accept;
    logic                                full;
    logic                                empty;
    logic [blist_pkg::CMP_W-1:0]         pos_ext;
    logic [blist_pkg::CMP_W-1:0]         cnt_ext;
    logic                                ins_bad;
    logic                                del_bad;
    logic [blist_pkg::POS_W-1:0]         pos_m1;
    logic [blist_pkg::CNT_W-1:0]         cnt_m1;
    blist_pkg::stat_t                    edit_stat;
    logic [blist_pkg::CNT_W-1:0]         edit_count;
    logic                                disp_start;
    blist_pkg::cell_ctrl_t               edit_ctrl;
    blist_pkg::cell_ctrl_t               ctrl;

    logic signed [blist_pkg::DATA_W-1:0] cell_val [blist_pkg::DEPTH];

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == ST_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;

    assign full    = (count_reg == blist_pkg::CNT_W'(blist_pkg::DEPTH));
    assign empty   = (count_reg == '0);
    assign pos_ext = blist_pkg::CMP_W'(position);
    assign cnt_ext = blist_pkg::CMP_W'(count_reg);
    assign ins_bad = (position == '0) || (pos_ext > (cnt_ext + blist_pkg::CMP_W'(1)));
    assign del_bad = (position == '0) || (pos_ext > cnt_ext);
    assign pos_m1  = position - blist_pkg::POS_W'(1);
    assign cnt_m1  = count_reg - blist_pkg::CNT_W'(1);

    always_comb
    begin
        edit_stat       = blist_pkg::STAT_OK;
        edit_count      = count_reg;
        disp_start      = 1'b0;
        edit_ctrl.op    = blist_pkg::SH_HOLD;
        edit_ctrl.idx   = '0;
        edit_ctrl.value = data_value;
        unique case (command)
            blist_pkg::CMD_APPEND:
            begin
                if (full)
                begin
                    edit_stat = blist_pkg::STAT_FULL;
                end
                else
                begin
                    edit_ctrl.op  = blist_pkg::SH_INSERT;
                    edit_ctrl.idx = blist_pkg::IDX_W'(count_reg);
                    edit_count    = count_reg + blist_pkg::CNT_W'(1);
                end
            end
            blist_pkg::CMD_INS_FRONT:
            begin
                if (full)
                begin
                    edit_stat = blist_pkg::STAT_FULL;
                end
                else
                begin
                    edit_ctrl.op = blist_pkg::SH_INSERT;
                    edit_count   = count_reg + blist_pkg::CNT_W'(1);
                end
            end
            blist_pkg::CMD_INS_POS:
            begin
                if (full)
                begin
                    edit_stat = blist_pkg::STAT_FULL;
                end
                else if (ins_bad)
                begin
                    edit_stat = blist_pkg::STAT_BADPOS;
                end
                else
                begin
                    edit_ctrl.op  = blist_pkg::SH_INSERT;
                    edit_ctrl.idx = blist_pkg::IDX_W'(pos_m1);
                    edit_count    = count_reg + blist_pkg::CNT_W'(1);
                end
            end
            blist_pkg::CMD_DEL_FRONT:
            begin
                if (empty)
                begin
                    edit_stat = blist_pkg::STAT_EMPTY;
                end
                else
                begin
                    edit_ctrl.op = blist_pkg::SH_DELETE;
                    edit_count   = cnt_m1;
                end
            end
            blist_pkg::CMD_DEL_BACK:
            begin
                if (empty)
                begin
                    edit_stat = blist_pkg::STAT_EMPTY;
                end
                else
                begin
                    edit_count = cnt_m1;
                end
            end
            blist_pkg::CMD_DEL_POS:
            begin
                if (empty)
                begin
                    edit_stat = blist_pkg::STAT_EMPTY;
                end
                else if (del_bad)
                begin
                    edit_stat = blist_pkg::STAT_BADPOS;
                end
                else
                begin
                    edit_ctrl.op  = blist_pkg::SH_DELETE;
                    edit_ctrl.idx = blist_pkg::IDX_W'(pos_m1);
                    edit_count    = cnt_m1;
                end
            end
            blist_pkg::CMD_DISPLAY:
            begin
                if (empty)
                begin
                    edit_stat = blist_pkg::STAT_EMPTY;
                end
                else
                begin
                    disp_start = 1'b1;
                end
            end
            default:
            begin
                edit_stat = blist_pkg::STAT_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && out_stall;
        entry_next     = entry_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        ecount_next    = ecount_reg;
        ctrl.op        = blist_pkg::SH_HOLD;
        ctrl.idx       = '0;
        ctrl.value     = data_value;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next = edit_count;
                    ctrl       = edit_ctrl;
                    if (disp_start)
                    begin
                        state_next = ST_DISP;
                        rem_next   = count_reg;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        entry_next     = '0;
                        last_next      = 1'b1;
                        status_next    = edit_stat;
                        ecount_next    = edit_count;
                    end
                end
            end
            ST_DISP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    entry_next     = cell_val[0];
                    last_next      = (rem_reg == blist_pkg::CNT_W'(1));
                    status_next    = blist_pkg::STAT_OK;
                    ecount_next    = count_reg;
                    ctrl.op        = blist_pkg::SH_ROTATE;
                    ctrl.idx       = blist_pkg::IDX_W'(cnt_m1);
                    rem_next       = rem_reg - blist_pkg::CNT_W'(1);
                    if (rem_reg == blist_pkg::CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg  <= entry_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        ecount_reg <= ecount_next;
    end

    for (genvar i = 0; i < blist_pkg::DEPTH; i++)
    begin : g_cell
        logic signed [blist_pkg::DATA_W-1:0] left_val;
        logic signed [blist_pkg::DATA_W-1:0] right_val;

        if (i == 0)
        begin : g_first
            assign left_val = '0;
        end
        else
        begin : g_mid_left
            assign left_val = cell_val[i-1];
        end

        if (i == blist_pkg::DEPTH - 1)
        begin : g_last
            assign right_val = '0;
        end
        else
        begin : g_mid_right
            assign right_val = cell_val[i+1];
        end

        blist_cell u_cell (
            .clk       (clk),
            .cell_idx  (blist_pkg::IDX_W'(i)),
            .ctrl      (ctrl),
            .left_val  (left_val),
            .right_val (right_val),
            .front_val (cell_val[0]),
            .value_out (cell_val[i])
        );
    end

    assign out_valid   = out_valid_reg;
    assign entry_value = entry_reg;
    assign last        = last_reg;
    assign status      = status_reg;
    assign entry_count = ecount_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= blist_pkg::CNT_W'(blist_pkg::DEPTH))
        else $error("Entry count exceeds the list depth.");

    a_disp_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DISP) |=> (count_reg == $past(count_reg)))
        else $error("Entry count changed during a display.");

    a_disp_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DISP) |-> ((rem_reg != '0) && (rem_reg <= count_reg)))
        else $error("Display remainder is out of range.");

    a_disp_last: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DISP) && out_free && (rem_reg == blist_pkg::CNT_W'(1)))
        |=> (out_valid_reg && last_reg && (state_reg == ST_IDLE)))
        else $error("Final display transaction was not marked last.");

endmodule
